// ----- rtl/core/binary_max_heap_queue_defines.svh -----
// assertion macros used by the heap queue top level
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BMHQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BMHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bmhq_pkg.sv -----
// shared types and constants for the heap queue
package bmhq_pkg;

  localparam int ID_W        = 16;
  localparam int PRIO_IN_W   = 16;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic {
    CMP_UP   = 1'b0,
    CMP_DOWN = 1'b1
  } cmp_mode_t;

  typedef struct packed {
    logic pick_right;
    logic promote;
  } cmp_res_t;

endpackage

// ----- rtl/core/binary_max_heap_queue.sv -----
// top level of the binary max-heap priority queue
//
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready   | tuser: op; tdata: priority_req, item_id
// out_    | out | out_tvalid / out_tready | tuser: status; tdata: out_priority,
//         |     |                         |        out_id, count
//
// from one accepted transfer to the next an item walks the heap level by level:
// each heap level costs a read state and a compare/write state, set
// by the registered read of the single heap memory and the one shared compare unit
// in_tready is high only in the idle state; one item is worked on at a time
// reset clears the count and the state, the memory needs no clearing pass
// since only positions up to the count are ever read
// a result waiting on out_tready holds the block in its final state
`include "binary_max_heap_queue_defines.svh"

module binary_max_heap_queue #(
  parameter int CAPACITY  = 64,
  parameter int PRIO_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] op
  input  logic [31:0] in_tdata,   // [15:0] priority_req, [31:16] item_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [39:0] out_tdata   // [15:0] out_priority, [31:16] out_id,
                                  // [38:32] count, [39] zero pad
);

  localparam int ID_W = bmhq_pkg::ID_W;
  localparam int EW   = PRIO_BITS + ID_W;             // stored entry width
  localparam int AW   = $clog2(CAPACITY);             // memory address width
  localparam int PW   = $clog2(CAPACITY + 1);         // position and count width
  localparam int XW   = (PRIO_BITS > bmhq_pkg::PRIO_IN_W) ? PRIO_BITS : bmhq_pkg::PRIO_IN_W;
  localparam int KW   = (PW > bmhq_pkg::COUNT_OUT_W) ? PW : bmhq_pkg::COUNT_OUT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RM_RD,
    S_RM_CAP,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PW-1:0]          cnt_r, cnt_nxt;      // entries held
  logic [PW-1:0]          pos_r, pos_nxt;      // one-based hole position
  logic [PW-1:0]          child_r, child_nxt;  // left child under compare
  logic [EW-1:0]          mov_r, mov_nxt;      // entry being sifted
  logic [EW-1:0]          res_r, res_nxt;      // removed root
  bmhq_pkg::status_t      status_r, status_nxt;

  logic                   out_valid_r, out_valid_nxt;
  bmhq_pkg::status_t      out_status_r, out_status_nxt;
  logic [15:0]            out_prio_r, out_prio_nxt;
  logic [ID_W-1:0]        out_id_r, out_id_nxt;
  logic [6:0]             out_count_r, out_count_nxt;

  // memory and compare unit hookup
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;
  logic [AW-1:0]          rd_addr_a;
  logic [AW-1:0]          rd_addr_b;
  logic [EW-1:0]          rd_data_a;
  logic [EW-1:0]          rd_data_b;
  bmhq_pkg::cmp_mode_t    cmp_mode;
  logic                   cmp_b_valid;
  bmhq_pkg::cmp_res_t     cmp_res;

  // width adaption of the priority field, higher bits are dropped
  logic [XW-1:0]          prio_in_wide;
  logic [PRIO_BITS-1:0]   prio_in;
  logic [XW-1:0]          res_prio_wide;
  logic [KW-1:0]          cnt_wide;
  logic [PW:0]            child_w;

  // accepted transfers that change the count, and the compare states
  logic                   ins_go;
  logic                   rm_go;
  logic                   in_cmp;

  assign prio_in_wide  = XW'(in_tdata[15:0]);
  assign prio_in       = prio_in_wide[PRIO_BITS-1:0];
  assign res_prio_wide = XW'(res_r[EW-1:ID_W]);
  assign cnt_wide      = KW'(cnt_r);
  assign child_w       = {pos_r, 1'b0};

  bmhq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (EW),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  bmhq_cmp #(
    .PRIO_BITS (PRIO_BITS)
  ) u_cmp (
    .mode     (cmp_mode),
    .mov_prio (mov_r[EW-1:ID_W]),
    .a_prio   (rd_data_a[EW-1:ID_W]),
    .b_prio   (rd_data_b[EW-1:ID_W]),
    .b_valid  (cmp_b_valid),
    .res      (cmp_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_count_r, out_id_r, out_prio_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    child_nxt      = child_r;
    mov_nxt        = mov_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_prio_nxt   = out_prio_r;
    out_id_nxt     = out_id_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = AW'(pos_r - PW'(1));
    wr_data        = mov_r;
    rd_addr_a      = '0;
    rd_addr_b      = '0;
    cmp_mode       = bmhq_pkg::CMP_UP;
    cmp_b_valid    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mov_nxt    = {prio_in, in_tdata[31:16]};
          res_nxt    = '0;
          status_nxt = bmhq_pkg::ST_DONE;
          if (bmhq_pkg::op_t'(in_tuser) == bmhq_pkg::OP_INSERT) begin
            if (cnt_r == PW'(CAPACITY)) begin
              status_nxt = bmhq_pkg::ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              cnt_nxt   = cnt_r + PW'(1);
              pos_nxt   = cnt_r + PW'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = bmhq_pkg::ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              cnt_nxt   = cnt_r - PW'(1);
              state_nxt = S_RM_RD;
            end
          end
        end
      end
      S_RM_RD: begin
        // fetch root and last entry together, the count is already shrunk
        rd_addr_a = '0;
        rd_addr_b = AW'(cnt_r);
        state_nxt = S_RM_CAP;
      end
      S_RM_CAP: begin
        res_nxt = rd_data_a;
        mov_nxt = rd_data_b;
        pos_nxt = PW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (pos_r == PW'(1)) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_addr_a = AW'((pos_r >> 1) - PW'(1));
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmp_mode = bmhq_pkg::CMP_UP;
        wr_en    = 1'b1;
        if (cmp_res.promote) begin
          // parent moves down into the hole
          wr_data   = rd_data_a;
          pos_nxt   = pos_r >> 1;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_RD: begin
        if (child_w > (PW + 1)'(cnt_r)) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_addr_a = AW'(child_w - (PW + 1)'(1));
          rd_addr_b = AW'(child_w);
          child_nxt = PW'(child_w);
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmp_mode    = bmhq_pkg::CMP_DOWN;
        cmp_b_valid = child_r < cnt_r;
        wr_en       = 1'b1;
        if (cmp_res.promote) begin
          // larger child moves up into the hole
          wr_data   = cmp_res.pick_right ? rd_data_b : rd_data_a;
          pos_nxt   = cmp_res.pick_right ? child_r + PW'(1) : child_r;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_prio_nxt   = res_prio_wide[15:0];
          out_id_nxt     = res_r[ID_W-1:0];
          out_count_nxt  = cnt_wide[6:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    child_r      <= child_nxt;
    mov_r        <= mov_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_prio_r   <= out_prio_nxt;
    out_id_r     <= out_id_nxt;
    out_count_r  <= out_count_nxt;
  end

  // checks
  assign ins_go = in_tvalid && in_tready && in_tuser == bmhq_pkg::OP_INSERT
                  && cnt_r != PW'(CAPACITY);
  assign rm_go  = in_tvalid && in_tready && in_tuser == bmhq_pkg::OP_REMOVE && cnt_r != '0;
  assign in_cmp = state_r == S_UP_CMP || state_r == S_DN_CMP;

  `BMHQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, cnt_r <= PW'(CAPACITY), "count above capacity")

  `BMHQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, ins_go, cnt_r == $past(cnt_r) + PW'(1), "no growth")

  `BMHQ_ASSERT_NEXT(a_remove_shrinks, clk, rst_n, rm_go, cnt_r == $past(cnt_r) - PW'(1), "no shrink")

  `BMHQ_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid_r && out_status_r != bmhq_pkg::ST_DONE, out_prio_r == '0 && out_id_r == '0, "failed transfer carries an entry")

  `BMHQ_ASSERT_IMPL(a_sift_pos, clk, rst_n, in_cmp, pos_r != '0 && pos_r <= cnt_r, "sift position outside heap")

endmodule

// ----- rtl/core/bmhq_store.sv -----
// heap entry memory: one write port, two registered read ports
module bmhq_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- rtl/core/bmhq_cmp.sv -----
// shared priority compare unit for sift-up and sift-down steps
module bmhq_cmp #(
  parameter int PRIO_BITS = 16
) (
  input  bmhq_pkg::cmp_mode_t   mode,
  input  logic [PRIO_BITS-1:0]  mov_prio,
  input  logic [PRIO_BITS-1:0]  a_prio,
  input  logic [PRIO_BITS-1:0]  b_prio,
  input  logic                  b_valid,
  output bmhq_pkg::cmp_res_t    res
);

  logic                 pick_b;
  logic [PRIO_BITS-1:0] chosen;
  logic [PRIO_BITS-1:0] lhs;
  logic [PRIO_BITS-1:0] rhs;

  // right child only when strictly greater, ties go left
  assign pick_b = b_valid && (b_prio > a_prio);
  assign chosen = pick_b ? b_prio : a_prio;

  // up: moving entry beats parent; down: chosen child beats moving entry
  assign lhs = (mode == bmhq_pkg::CMP_UP) ? mov_prio : chosen;
  assign rhs = (mode == bmhq_pkg::CMP_UP) ? a_prio : mov_prio;

  assign res.pick_right = pick_b;
  assign res.promote    = lhs > rhs;

endmodule

// ----- bench/binary_max_heap_queue_checker.sv -----
// checker for the heap queue: shadow heap, expected-result queue and field compare
module binary_max_heap_queue_checker #(
  parameter int CAPACITY  = 64,
  parameter int PRIO_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] op
  input  logic [31:0] in_tdata,   // [15:0] priority_req, [31:16] item_id
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic [39:0] out_tdata,  // [15:0] out_priority, [31:16] out_id, [38:32] count, [39] pad
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bmhq_pkg::status_t status;
    logic [15:0]       prio;
    logic [15:0]       id;
    logic [6:0]        count;
  } heap_result_t;

  // shadow copy of the heap, one-based
  logic [PRIO_BITS-1:0] heap_prio [1:CAPACITY];
  logic [15:0]          heap_id   [1:CAPACITY];
  int                   heap_cnt = 0;

  heap_result_t pending_results [$];
  heap_result_t want;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic void swap_entries(int a, int b);
    logic [PRIO_BITS-1:0] tp;
    logic [15:0]          tid;
    tp           = heap_prio[a];
    tid          = heap_id[a];
    heap_prio[a] = heap_prio[b];
    heap_id[a]   = heap_id[b];
    heap_prio[b] = tp;
    heap_id[b]   = tid;
  endfunction

  function automatic heap_result_t heap_step(bmhq_pkg::op_t op, logic [15:0] prio_in,
                                             logic [15:0] id_in);
    heap_result_t res;
    int pos;
    int child;
    res.status = bmhq_pkg::ST_DONE;
    res.prio   = '0;
    res.id     = '0;
    if (op == bmhq_pkg::OP_INSERT) begin
      if (heap_cnt >= CAPACITY) begin
        res.status = bmhq_pkg::ST_FULL;
      end else begin
        heap_cnt++;
        heap_prio[heap_cnt] = prio_in[PRIO_BITS-1:0];
        heap_id[heap_cnt]   = id_in;
        pos = heap_cnt;
        // ties stay where they are
        while (pos > 1 && heap_prio[pos] > heap_prio[pos/2]) begin
          swap_entries(pos, pos / 2);
          pos = pos / 2;
        end
      end
    end else if (heap_cnt == 0) begin
      res.status = bmhq_pkg::ST_EMPTY;
    end else begin
      res.prio     = 16'(heap_prio[1]);
      res.id       = heap_id[1];
      heap_prio[1] = heap_prio[heap_cnt];
      heap_id[1]   = heap_id[heap_cnt];
      heap_cnt--;
      pos = 1;
      while (2 * pos <= heap_cnt) begin
        child = 2 * pos;
        // right child only when strictly larger
        if (child < heap_cnt && heap_prio[child+1] > heap_prio[child]) child++;
        if (heap_prio[child] > heap_prio[pos]) begin
          swap_entries(pos, child);
          pos = child;
        end else begin
          break;
        end
      end
    end
    res.count = 7'(heap_cnt);
    return res;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      heap_cnt = 0;
      pending_results.delete();
    end else begin
      // results first: a result always belongs to an older transfer
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $error("result transfer with no expectation pending");
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("out_priority", want.prio, out_tdata[15:0]);
          check_field("out_id", want.id, out_tdata[31:16]);
          check_field("count", want.count, out_tdata[38:32]);
          check_field("pad", 0, out_tdata[39]);
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(heap_step(bmhq_pkg::op_t'(in_tuser[0]), in_tdata[15:0],
                                            in_tdata[31:16]));
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- bench/binary_max_heap_queue_tb.sv -----
// top of the heap queue bench: clock, reset, stimulus, back-pressure and verdict
module binary_max_heap_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 64;
  localparam int PRIO_BITS    = 16;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASE_ITEMS  = 120;   // items per fill / drain / mixed phase
  localparam int HOLD_AT      = 300;   // results taken before the long hold-off
  localparam int HOLD_CYCLES  = 400;   // length of the long hold-off
  localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer before giving up
  localparam int TAIL_CYCLES  = 40;    // quiet cycles after the last result

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [0:0]  in_tuser;   // [0] op
  logic [31:0] in_tdata;   // [15:0] priority_req, [31:16] item_id
  logic        out_tvalid;
  logic        out_tready;
  logic [1:0]  out_tuser;  // [1:0] status
  logic [39:0] out_tdata;  // [15:0] out_priority, [31:16] out_id, [38:32] count, [39] pad

  int errors;
  int outstanding;
  int idle_cycles = 0;

  binary_max_heap_queue #(
    .CAPACITY  (CAPACITY),
    .PRIO_BITS (PRIO_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  binary_max_heap_queue_checker #(
    .CAPACITY  (CAPACITY),
    .PRIO_BITS (PRIO_BITS)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // gap lengths: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // narrow range for ties, the two extremes, or anything at all
  function automatic logic [15:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 7));
    if (r < 60) return 16'h0000;
    if (r < 70) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // offer one item after a random gap and hold it until the transfer
  task automatic push_item(bmhq_pkg::op_t op, logic [15:0] prio, logic [15:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {id, prio};
    do @(posedge clk); while (!in_tready);
  endtask

  // watchdog: any transfer restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up its input
  initial begin
    int  gap;
    int  taken;
    bit  held;
    out_tready = 1'b0;
    taken      = 0;
    held       = 1'b0;
    wait (rst_n);
    forever begin
      gap = pick_gap();
      if (!held && taken >= HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin
    bmhq_pkg::op_t op;
    int            ins_pct;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = '0;
    in_tdata   = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // remove on an empty heap, payload bits high and low
    push_item(bmhq_pkg::OP_REMOVE, 16'hFFFF, 16'hFFFF);
    push_item(bmhq_pkg::OP_REMOVE, 16'h0000, 16'h0000);
    // field extremes and a tie with the root
    push_item(bmhq_pkg::OP_INSERT, 16'h0000, 16'h0000);
    push_item(bmhq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF);
    push_item(bmhq_pkg::OP_INSERT, 16'hFFFF, 16'h0001);
    push_item(bmhq_pkg::OP_INSERT, 16'h0008, 16'h000A);
    push_item(bmhq_pkg::OP_INSERT, 16'h0008, 16'h000B);
    push_item(bmhq_pkg::OP_INSERT, 16'h0000, 16'hFFFF);
    // drain completely, children with equal priority on the way
    repeat (6) push_item(bmhq_pkg::OP_REMOVE, 16'h0000, 16'h0000);
    push_item(bmhq_pkg::OP_REMOVE, 16'h1234, 16'h5678);
    // all-equal priorities keep insertion structure
    push_item(bmhq_pkg::OP_INSERT, 16'h0005, 16'h000A);
    push_item(bmhq_pkg::OP_INSERT, 16'h0005, 16'h000B);
    push_item(bmhq_pkg::OP_INSERT, 16'h0005, 16'h000C);
    repeat (3) push_item(bmhq_pkg::OP_REMOVE, 16'h0000, 16'h0000);

    // random part in rotating phases: fill to overflow, drain to underflow, mixed
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      case ((k / PHASE_ITEMS) % 3)
        0: ins_pct = 90;
        1: ins_pct = 10;
        default: ins_pct = 50;
      endcase
      op = ($urandom_range(0, 99) < ins_pct) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_REMOVE;
      push_item(op, pick_prio(), 16'($urandom));
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
